// ----- rtl/marching_cubes_voxel_triangulator_top_assert.svh -----
// Assertion macros for the voxel triangulator.
// Included by the top level; no other dependencies.
`ifndef MARCHING_CUBES_VOXEL_TRIANGULATOR_TOP_ASSERT_SVH
`define MARCHING_CUBES_VOXEL_TRIANGULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MCVT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcvt assertion failed");
`define MCVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcvt assertion failed");
`else
`define MCVT_ASSERT_IMPL(lbl, ante, cons)
`define MCVT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/mcvt_pkg.sv -----
// Shared types, edge tables and the triangle table of the triangulator.
// No dependencies.
package mcvt_pkg;

  localparam int GRID_RES_DFLT = 256;
  localparam int NUM_EDGES     = 12;
  localparam int CFG_W         = 24;

  typedef enum logic [1:0] {REG_ISO, REG_CSX, REG_CSY, REG_CSZ} cfg_reg_t;
  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_WAIT, ST_EMIT} mc_state_t;
  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  // Corner coordinates: index*cell (0) and (index+1)*cell (1) per axis
  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] y0;
    logic [31:0] y1;
    logic [31:0] z0;
    logic [31:0] z1;
  } corner_pos_t;

  localparam logic [2:0] EDGE_A [NUM_EDGES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                                3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_B [NUM_EDGES] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
                                                3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam axis_t EDGE_AXIS [NUM_EDGES] = '{AX_X, AX_Z, AX_X, AX_Z, AX_X, AX_Z,
                                              AX_X, AX_Z, AX_Y, AX_Y, AX_Y, AX_Y};
  // edge runs toward the lower coordinate
  localparam logic EDGE_NEG [NUM_EDGES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                            1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam logic OFF_X [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic OFF_Y [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam logic OFF_Z [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  // Triangle lists: one nibble per edge, first edge most significant,
  // terminated above by an F nibble.
  localparam logic [63:0] TRI_TBL [256] = '{
    64'hF, 64'hF083, 64'hF019, 64'hF183981, 64'hF12a, 64'hF08312a, 64'hF92a029,
    64'hF2832a8a98,
    64'hF3b2, 64'hF0b28b0, 64'hF19023b, 64'hF1b219b98b, 64'hF3a1ba3, 64'hF0a108a8ba,
    64'hF3903b9ba9, 64'hF98aa8b,
    64'hF478, 64'hF430734, 64'hF019847, 64'hF419471731, 64'hF12a847, 64'hF34730412a,
    64'hF92a902847, 64'hF2a9297273794,
    64'hF8473b2, 64'hFb47b24204, 64'hF90184723b, 64'hF47b94b9b2921, 64'hF3a13ba784,
    64'hF1ba14b1047b4, 64'hF47890b9bab03, 64'hF47b4b99ba,
    64'hF954, 64'hF954083, 64'hF054150, 64'hF854835315, 64'hF12a954, 64'hF30812a495,
    64'hF52a542402, 64'hF2a5325354348,
    64'hF95423b, 64'hF0b208b495, 64'hF05401523b, 64'hF21525828b485, 64'hFa3ba13954,
    64'hF4950818a18ba, 64'hF54050b5bab03, 64'hF5485a8a8b,
    64'hF978579, 64'hF930953573, 64'hF078017157, 64'hF153357, 64'hF978957a12,
    64'hFa12950530573, 64'hF802825857a52, 64'hF2a5253357,
    64'hF7957893b2, 64'hF95797292027b, 64'hF23b018178157, 64'hFb21b17715,
    64'hF958857a13a3b, 64'hF5705097b010aba0, 64'hFba0b03a50807570, 64'hFba57b5,
    64'hFa65, 64'hF0835a6, 64'hF9015a6, 64'hF1831985a6, 64'hF165261, 64'hF165126308,
    64'hF965906026, 64'hF598582526328,
    64'hF23ba65, 64'hFb08b20a65, 64'hF01923b5a6, 64'hF5a61929b298b, 64'hF63b653513,
    64'hF08b0b50515b6, 64'hF3b6036065059, 64'hF65969bb98,
    64'hF5a6478, 64'hF43047365a, 64'hF1905a6847, 64'hFa65197173794, 64'hF612651478,
    64'hF125526304347, 64'hF847905065026, 64'hF739794329596269,
    64'hF3b2784a65, 64'hF5a647242027b, 64'hF01947823b5a6, 64'hF9219b294b7b45a6,
    64'hF8473b53515b6, 64'hF51b5b610b7b404b, 64'hF059065036b63847, 64'hF65969b4797b9,
    64'hFa4964a, 64'hF4a649a083, 64'hFa01a60640, 64'hF83181686461a, 64'hF149124264,
    64'hF308129249264, 64'hF024426, 64'hF832824426,
    64'hFa49a64b23, 64'hF08228b49a4a6, 64'hF3b201606461a, 64'hF64161a48121b8b1,
    64'hF964936913b63, 64'hF8b1810b61914641, 64'hF3b6360064, 64'hF648b68,
    64'hF7a678a89a, 64'hF0730a709a67a, 64'hFa671a7178180, 64'hFa67a71173,
    64'hF126168189867, 64'hF269291679093739, 64'hF780706602, 64'hF732672,
    64'hF23ba68a89867, 64'hF20727b09767a9a7, 64'hF1801781a767a23b, 64'hFb21b17a61671,
    64'hF896867916b63136, 64'hF091b67, 64'hF7807063b0b60, 64'hF7b6,
    64'hF76b, 64'hF308b76, 64'hF019b76, 64'hF819831b76, 64'hFa126b7, 64'hF12a3086b7,
    64'hF2902a96b7, 64'hF6b72a3a83a98,
    64'hF723627, 64'hF708760620, 64'hF276237019, 64'hF162186198876, 64'hFa76a17137,
    64'hFa7617a187108, 64'hF03707a0a96a7, 64'hF76a7a88a9,
    64'hF684b86, 64'hF36b306046, 64'hF86b846901, 64'hF946963931b36, 64'hF6846b82a1,
    64'hF12a30b06b046, 64'hF4b846b0292a9, 64'hFa93a32943b36463,
    64'hF823842462, 64'hF042462, 64'hF190234246438, 64'hF194142246,
    64'hF8138618466a1, 64'hFa10a06604, 64'hF4634386a3039a93, 64'hFa946a4,
    64'hF49576b, 64'hF083495b76, 64'hF50154076b, 64'hFb76834354315, 64'hF954a1276b,
    64'hF6b712a083495, 64'hF76b54a42a402, 64'hF348354325a52b76,
    64'hF723762549, 64'hF954086062687, 64'hF362376150540, 64'hF628687218485158,
    64'hF954a16176137, 64'hF16a176107870954, 64'hF40a4a503a6a737a, 64'hF76a7a854a48a,
    64'hF6956b9b89, 64'hF36b063056095, 64'hF0b805b01556b, 64'hF6b3635531,
    64'hF12a95b9b8b56, 64'hF0b306b09656912a, 64'hFb85b56805a52025, 64'hF6b36352a3a53,
    64'hF589528562382, 64'hF956960062, 64'hF158180568382628, 64'hF156216,
    64'hF13616a386569896, 64'hFa10a06950560, 64'hF03856a, 64'hFa56,
    64'hFb5a75b, 64'hFb5ab75830, 64'hF5b75ab190, 64'hFa75ab7981831, 64'hFb12b71751,
    64'hF08312717572b, 64'hF9759279022b7, 64'hF75272b592328982,
    64'hF25a235375, 64'hF820852875a25, 64'hF9015a35373a2, 64'hF982921872a25752,
    64'hF135375, 64'hF087071175, 64'hF903935537, 64'hF987597,
    64'hF5845a8ab8, 64'hF5045b05abb30, 64'hF01984a8aba45, 64'hFab4a45b34941314,
    64'hF2512852b8458, 64'hF04b0b345b2b151b, 64'hF0250592b5458b85, 64'hF9452b3,
    64'hF25a352345384, 64'hF5a2524420, 64'hF3a235a385458019, 64'hF5a2524192942,
    64'hF845853351, 64'hF045105, 64'hF845853905035, 64'hF945,
    64'hF4b749b9ab, 64'hF0834979b79ab, 64'hF1ab1b414074b, 64'hF3143481a474bab4,
    64'hF4b79b492b912, 64'hF9749b791b2b1083, 64'hFb74b42240, 64'hFb74b42834324,
    64'hF29a279237749, 64'hF9a7974a27870207, 64'hF37a3a274a1a040a, 64'hF1a2874,
    64'hF491417713, 64'hF491417081871, 64'hF403743, 64'hF487,
    64'hF9a8ab8, 64'hF30939bb9a, 64'hF01a0a88ab, 64'hF31ab3a, 64'hF12b1b99b8,
    64'hF30939b1292b9, 64'hF02b80b, 64'hF32b,
    64'hF23828aa89, 64'hF9a2092, 64'hF23828a0181a8, 64'hF1a2, 64'hF138918, 64'hF091,
    64'hF038, 64'hF
  };

  // number of edge nibbles below the terminator
  function automatic logic [3:0] tri_len(input logic [63:0] ent);
    logic [3:0] len;
    len = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (ent[i*4 +: 4] == 4'hF) begin
        len = 4'(i);
      end
    end
    return len;
  endfunction

endpackage

// ----- rtl/mcvt_lane.sv -----
// One edge lane: fixed-point mu by restoring division, then the vertex
// coordinate along the edge's axis. No package dependencies.
module mcvt_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic        [15:0] iso,
  input  logic signed [17:0] da,
  input  logic signed [17:0] db,
  input  logic        [23:0] cell_len,
  input  logic        [31:0] pa,
  input  logic               neg,
  output logic        [31:0] result,
  output logic               done
);

  localparam int QW = 16;
  localparam logic [4:0] C_ABS  = 5'd1;
  localparam logic [4:0] C_SAT  = 5'd2;
  localparam logic [4:0] C_DIV0 = 5'd3;
  localparam logic [4:0] C_MUL  = 5'(C_DIV0 + QW);
  localparam logic [4:0] C_ADD  = 5'(C_MUL + 1);

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic signed [18:0] num_r, den_r;
  logic [17:0]       n_r, d_r, rem_r;
  logic              zero_r, sat_r;
  logic [QW-1:0]     q_r;
  logic [40:0]       prod_r;
  logic [31:0]       result_r;
  logic              done_r;

  logic [18:0] rem2;
  logic        ge;
  logic [17:0] rem_nxt;
  logic [16:0] mu;
  logic [31:0] off;

  assign rem2    = {rem_r, 1'b0};
  assign ge      = rem2 >= {1'b0, d_r};
  assign rem_nxt = ge ? 18'(rem2 - {1'b0, d_r}) : rem2[17:0];
  assign mu      = zero_r ? 17'd0 : (sat_r ? 17'h10000 : {1'b0, q_r});
  assign off     = {7'd0, prod_r[40:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= C_ABS;
      done_r <= 1'b0;
      num_r  <= $signed({3'b000, iso}) - 19'(da);
      den_r  <= 19'(db) - 19'(da);
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == C_ABS) begin
        zero_r <= (num_r == 19'sd0) || (den_r == 19'sd0) || (num_r[18] != den_r[18]);
        n_r    <= num_r[18] ? 18'(-num_r) : num_r[17:0];
        d_r    <= den_r[18] ? 18'(-den_r) : den_r[17:0];
      end else if (cnt_r == C_SAT) begin
        sat_r <= n_r >= d_r;
        rem_r <= n_r;
        q_r   <= '0;
      end else if (cnt_r < C_MUL) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[QW-2:0], ge};
      end else if (cnt_r == C_MUL) begin
        prod_r <= cell_len * mu;
      end else begin
        result_r <= neg ? pa - off : pa + off;
        done_r   <= 1'b1;
        busy_r   <= 1'b0;
      end
    end
  end

  assign result = result_r;
  assign done   = done_r && (cnt_r == C_ADD + 5'd1 || !busy_r);

endmodule

// ----- rtl/mcvt_emit.sv -----
// Merge stage: walks the triangle list and assembles each vertex from the
// lane results and corner positions. Depends on mcvt_pkg.
module mcvt_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [7:0]           ci,
  input  logic                 go,
  input  logic [31:0]          lane_res [mcvt_pkg::NUM_EDGES],
  input  mcvt_pkg::corner_pos_t pos,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [31:0]          out_point_x,
  output logic [31:0]          out_point_y,
  output logic [31:0]          out_point_z,
  output logic                 out_last_point,
  output logic                 busy
);
  import mcvt_pkg::*;

  logic [63:0] entry_r;
  logic [3:0]  len_r, k_r;
  logic        run_r, out_valid_r;
  logic [31:0] px_r, py_r, pz_r;
  logic        last_r;

  logic [3:0] p, nib, e;
  logic [2:0] a;
  logic [31:0] vx, vy, vz;
  logic        adv, is_last;

  assign p       = len_r - 4'd1 - k_r;
  assign nib     = entry_r[{p, 2'b00} +: 4];
  assign e       = (nib > 4'd11) ? 4'd0 : nib;
  assign a       = EDGE_A[e];
  assign vx      = (EDGE_AXIS[e] == AX_X) ? lane_res[e] : (OFF_X[a] ? pos.x1 : pos.x0);
  assign vy      = (EDGE_AXIS[e] == AX_Y) ? lane_res[e] : (OFF_Y[a] ? pos.y1 : pos.y0);
  assign vz      = (EDGE_AXIS[e] == AX_Z) ? lane_res[e] : (OFF_Z[a] ? pos.z1 : pos.z0);
  assign adv     = run_r && (!out_valid_r || !out_stall);
  assign is_last = k_r == len_r - 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= 4'd0;
      k_r         <= 4'd0;
    end else begin
      if (load) begin
        entry_r <= TRI_TBL[ci];
        len_r   <= tri_len(TRI_TBL[ci]);
      end
      if (go) begin
        run_r <= 1'b1;
        k_r   <= 4'd0;
      end
      if (adv) begin
        px_r        <= vx;
        py_r        <= vy;
        pz_r        <= vz;
        last_r      <= is_last;
        out_valid_r <= 1'b1;
        k_r         <= k_r + 4'd1;
        if (is_last) begin
          run_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;
  assign out_point_z    = pz_r;
  assign out_last_point = last_r;
  assign busy           = run_r;

endmodule

// ----- rtl/marching_cubes_voxel_triangulator_top.sv -----
// Top level of the marching cubes voxel triangulator.
// Depends on mcvt_pkg, mcvt_lane, mcvt_emit and the assertion header.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | voxel indices, 8 corners, weight mask
//   out_    | output    | out_valid/out_stall| point x/y/z Q16.16, last_point
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// A voxel with a missing weight or off the grid is rejected in the idle state;
// one entirely inside or outside the surface goes through the prep state only.
// A surface voxel waits for the 16-step divider in the edge lanes, then leaves
// one vertex per cycle from the output register while out_stall is low.
// Reset clears control and returns configuration to iso 0, cell 1.0.
// An output stall holds the vertex; with the last one held, the next voxel is taken.
`include "marching_cubes_voxel_triangulator_top_assert.svh"
module marching_cubes_voxel_triangulator_top #(
  parameter int GRID_RES = mcvt_pkg::GRID_RES_DFLT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_voxel_x,
  input  logic [7:0]                in_voxel_y,
  input  logic [7:0]                in_voxel_z,
  input  logic signed [17:0]        in_corner_0,
  input  logic signed [17:0]        in_corner_1,
  input  logic signed [17:0]        in_corner_2,
  input  logic signed [17:0]        in_corner_3,
  input  logic signed [17:0]        in_corner_4,
  input  logic signed [17:0]        in_corner_5,
  input  logic signed [17:0]        in_corner_6,
  input  logic signed [17:0]        in_corner_7,
  input  logic [7:0]                in_weight_mask,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_point_x,
  output logic [31:0]               out_point_y,
  output logic [31:0]               out_point_z,
  output logic                      out_last_point,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [mcvt_pkg::CFG_W-1:0] cfg_wdata
);
  import mcvt_pkg::*;

  localparam logic [8:0] VMAX = 9'(GRID_RES - 2);

  // configuration
  logic [15:0] iso_r;
  logic [23:0] csx_r, csy_r, csz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= 16'd0;
      csx_r <= 24'h010000;
      csy_r <= 24'h010000;
      csz_r <= 24'h010000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ISO: iso_r <= cfg_wdata[15:0];
        REG_CSX: csx_r <= cfg_wdata;
        REG_CSY: csy_r <= cfg_wdata;
        REG_CSZ: csz_r <= cfg_wdata;
      endcase
    end
  end

  // input capture
  mc_state_t st_r, st_nxt;
  logic        acc, ok;
  logic signed [17:0] cin [8];
  logic signed [17:0] d_r [8];
  logic [7:0]  vx_r, vy_r, vz_r, ci_r, ci;
  corner_pos_t pos_r;

  assign cin = '{in_corner_0, in_corner_1, in_corner_2, in_corner_3,
                 in_corner_4, in_corner_5, in_corner_6, in_corner_7};
  assign acc = in_valid && !in_stall;
  assign ok  = (in_weight_mask == 8'hFF) && ({1'b0, in_voxel_x} <= VMAX) &&
               ({1'b0, in_voxel_y} <= VMAX) && ({1'b0, in_voxel_z} <= VMAX);

  // corner below the iso level sets its cube index bit
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ci[i] = cin[i] < $signed({2'b00, iso_r});
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      vx_r <= in_voxel_x;
      vy_r <= in_voxel_y;
      vz_r <= in_voxel_z;
      d_r  <= cin;
      ci_r <= ci;
    end
    if (st_r == ST_PREP) begin
      pos_r.x0 <= {24'd0, vx_r} * {8'd0, csx_r};
      pos_r.y0 <= {24'd0, vy_r} * {8'd0, csy_r};
      pos_r.z0 <= {24'd0, vz_r} * {8'd0, csz_r};
    end
    // far corner follows the near one; settled long before the lanes finish
    pos_r.x1 <= pos_r.x0 + 32'(csx_r);
    pos_r.y1 <= pos_r.y0 + 32'(csy_r);
    pos_r.z1 <= pos_r.z0 + 32'(csz_r);
  end

  // edge lanes, one per cube edge
  logic [NUM_EDGES-1:0] lane_done;
  logic [31:0]          lane_res [NUM_EDGES];
  logic                 lane_start;

  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_lane
    logic [23:0] edge_cell;
    logic [31:0] pa;
    assign edge_cell = (EDGE_AXIS[g] == AX_X) ? csx_r :
                       (EDGE_AXIS[g] == AX_Y) ? csy_r : csz_r;
    assign pa   = (EDGE_AXIS[g] == AX_X) ? (OFF_X[EDGE_A[g]] ? pos_r.x1 : pos_r.x0) :
                  (EDGE_AXIS[g] == AX_Y) ? (OFF_Y[EDGE_A[g]] ? pos_r.y1 : pos_r.y0) :
                                           (OFF_Z[EDGE_A[g]] ? pos_r.z1 : pos_r.z0);
    mcvt_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (lane_start),
      .iso      (iso_r),
      .da       (d_r[EDGE_A[g]]),
      .db       (d_r[EDGE_B[g]]),
      .cell_len (edge_cell),
      .pa       (pa),
      .neg      (EDGE_NEG[g]),
      .result   (lane_res[g]),
      .done     (lane_done[g])
    );
  end

  // sequencer
  logic emit_busy, emit_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    lane_start = 1'b0;
    emit_go    = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc && ok) begin
          st_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        lane_start = 1'b1;
        // empty triangle list: done with this voxel
        st_nxt = (tri_len(TRI_TBL[ci_r]) == 4'd0) ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (&lane_done) begin
          emit_go = 1'b1;
          st_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          st_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign in_stall = st_r != ST_IDLE;

  mcvt_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (lane_start),
    .ci             (ci_r),
    .go             (emit_go),
    .lane_res       (lane_res),
    .pos            (pos_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_last_point (out_last_point),
    .busy           (emit_busy)
  );

  // voxel with a missing weight never leaves the idle state
  `MCVT_ASSERT_NEXT(a_reject_idle, acc && in_weight_mask != 8'hFF, st_r == ST_IDLE)
  // vertices are only assembled from finished lanes
  `MCVT_ASSERT_IMPL(a_emit_lanes_done, st_r == ST_EMIT, &lane_done)
  // the emitter is quiet while lanes are still dividing
  `MCVT_ASSERT_IMPL(a_wait_quiet, st_r == ST_WAIT, !emit_busy)

endmodule

// ----- tb/tb_marching_cubes_voxel_triangulator_top.sv -----
// Self-checking testbench for the marching cubes voxel triangulator.
// Depends on mcvt_pkg and marching_cubes_voxel_triangulator_top; predicts every vertex.
module tb_marching_cubes_voxel_triangulator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcvt_pkg::*;

  localparam int RUN_LIMIT = 500000;
  localparam int SETTLE    = 60;

  // one voxel transaction as the sender sees it
  typedef struct {
    logic [7:0]        vx, vy, vz;
    logic signed [17:0] c[8];
    logic [7:0]        mask;
    bit                drain;      // hold until all vertices are back
  } voxel_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
  } vertex_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_voxel_x = '0, in_voxel_y = '0, in_voxel_z = '0;
  logic signed [17:0] in_corner_0 = '0, in_corner_1 = '0, in_corner_2 = '0, in_corner_3 = '0;
  logic signed [17:0] in_corner_4 = '0, in_corner_5 = '0, in_corner_6 = '0, in_corner_7 = '0;
  logic [7:0]         in_weight_mask = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_point_x, out_point_y, out_point_z;
  logic               out_last_point;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  marching_cubes_voxel_triangulator_top dut (.*);

  always #10 clk = ~clk;

  // Triangle lists, one hex digit per edge, three per triangle (standard table)
  string tri_edges [256] = '{
    "","083","019","183981","12a","08312a","92a029","2832a8a98",
    "3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
    "478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
    "8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4",
    "47890b9bab03","47b4b99ba",
    "954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
    "95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba",
    "54050b5bab03","5485a8a8b",
    "978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
    "2a5253357",
    "7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b",
    "5705097b010aba0","ba0b03a50807570","ba57b5",
    "a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
    "23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6",
    "3b6036065059","65969bb98",
    "5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347",
    "847905065026","739794329596269",
    "3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
    "51b5b610b7b404b","059065036b63847","65969b4797b9",
    "a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
    "832824426",
    "a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
    "8b1810b61914641","3b6360064","648b68",
    "7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867",
    "269291679093739","780706602","732672",
    "23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136",
    "091b67","7807063b0b60","7b6",
    "76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
    "723627","708760620","276237019","162186198876","a76a17137","a7617a187108",
    "03707a0a96a7","76a7a88a9",
    "684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046",
    "4b846b0292a9","a93a32943b36463",
    "823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
    "4634386a3039a93","a946a4",
    "49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495",
    "76b54a42a402","348354325a52b76",
    "723762549","954086062687","362376150540","628687218485158","954a16176137",
    "16a176107870954","40a4a503a6a737a","76a7a854a48a",
    "6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56",
    "0b306b09656912a","b85b56805a52025","6b36352a3a53",
    "589528562382","956960062","158180568382628","156216","13616a386569896",
    "a10a06950560","03856a","a56",
    "b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b71751","08312717572b",
    "9759279022b7","75272b592328982",
    "25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
    "903935537","987597",
    "5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
    "04b0b345b2b151b","0250592b5458b85","9452b3",
    "25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
    "845853905035","945",
    "4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
    "9749b791b2b1083","b74b42240","b74b42834324",
    "29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713",
    "491417081871","403743","487",
    "9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
    "23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
  };

  const int edge_lo [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
  const int edge_hi [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};
  const int dx [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
  const int dy [8] = '{0, 0, 0, 0, 1, 1, 1, 1};
  const int dz [8] = '{0, 0, 1, 1, 0, 0, 1, 1};

  // shadow copy of the registers
  logic [15:0] iso = 16'd0;
  logic [23:0] cell_x = 24'd65536, cell_y = 24'd65536, cell_z = 24'd65536;

  voxel_t  pending [$];
  vertex_t vertices_due [$];
  bit      failed = 0;
  bit      no_idle = 0;
  int      cycles = 0;

  // fraction of the way from da to db where the iso level sits, Q1.16
  function automatic longint edge_frac(longint da, longint db);
    longint num, den, q;
    num = longint'(iso) - da;
    den = db - da;
    if (num == 0 || den == 0 || ((num > 0) != (den > 0))) return 0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (num << 16) / den;
    return (q > 65536) ? 65536 : q;
  endfunction

  function automatic longint slide(longint pa, longint pb, longint mu);
    if (pb >= pa) return pa + (((pb - pa) * mu) >> 16);
    return pa - (((pa - pb) * mu) >> 16);
  endfunction

  // queue every vertex the voxel produces
  function automatic void triangulate(voxel_t v);
    longint px[8], py[8], pz[8];
    longint mu;
    int     cube, e, a, b, n;
    byte    ch;
    vertex_t vt;
    if (v.mask != 8'hFF || v.vx > 8'd254 || v.vy > 8'd254 || v.vz > 8'd254) return;
    cube = 0;
    for (int i = 0; i < 8; i++) begin
      if (longint'(v.c[i]) < longint'(iso)) cube |= 1 << i;
      px[i] = longint'(v.vx + dx[i]) * cell_x;
      py[i] = longint'(v.vy + dy[i]) * cell_y;
      pz[i] = longint'(v.vz + dz[i]) * cell_z;
    end
    n = tri_edges[cube].len();
    for (int k = 0; k < n; k++) begin
      ch = tri_edges[cube][k];
      e = (ch >= "a") ? ch - "a" + 10 : ch - "0";
      a = edge_lo[e];
      b = edge_hi[e];
      mu = edge_frac(v.c[a], v.c[b]);
      vt.x = 32'(slide(px[a], px[b], mu));
      vt.y = 32'(slide(py[a], py[b], mu));
      vt.z = 32'(slide(pz[a], pz[b], mu));
      vt.last = (k == n - 1);
      vertices_due = {vertices_due, vt};
    end
  endfunction

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Driver: one transaction per voxel, random gap after each accepted one
  int send_gap = 0;
  voxel_t on_bus;
  always @(posedge clk) begin
    bit     take, nxt;
    voxel_t nv;
    take = in_valid && !in_stall;
    nxt  = in_valid && !take;   // stalled payload stays put
    if (take) begin
      triangulate(on_bus);
      send_gap = draw_wait();
    end
    if (rst_n && !nxt) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending.size() > 0 &&
                   !(pending[0].drain && vertices_due.size() > 0)) begin
        nv = pending.pop_front();
        on_bus = nv;
        nxt = 1'b1;
        in_voxel_x     <= nv.vx;
        in_voxel_y     <= nv.vy;
        in_voxel_z     <= nv.vz;
        in_corner_0    <= nv.c[0];
        in_corner_1    <= nv.c[1];
        in_corner_2    <= nv.c[2];
        in_corner_3    <= nv.c[3];
        in_corner_4    <= nv.c[4];
        in_corner_5    <= nv.c[5];
        in_corner_6    <= nv.c[6];
        in_corner_7    <= nv.c[7];
        in_weight_mask <= nv.mask;
      end
    end
    in_valid <= nxt;
  end

  // Monitor: compare each vertex with the oldest one predicted
  int recv_hold = 0;
  always @(posedge clk) begin
    vertex_t ex;
    if (out_valid && !out_stall) begin
      if (vertices_due.size() == 0) begin
        $display("%0t: unexpected vertex x=%h y=%h z=%h last=%b", $time,
                 out_point_x, out_point_y, out_point_z, out_last_point);
        failed = 1;
      end else begin
        ex = vertices_due.pop_front();
        if (out_point_x !== ex.x) begin
          $display("%0t: point_x expected %h actual %h", $time, ex.x, out_point_x);
          failed = 1;
        end
        if (out_point_y !== ex.y) begin
          $display("%0t: point_y expected %h actual %h", $time, ex.y, out_point_y);
          failed = 1;
        end
        if (out_point_z !== ex.z) begin
          $display("%0t: point_z expected %h actual %h", $time, ex.z, out_point_z);
          failed = 1;
        end
        if (out_last_point !== ex.last) begin
          $display("%0t: last_point expected %b actual %b", $time, ex.last, out_last_point);
          failed = 1;
        end
      end
      recv_hold = draw_wait();
    end else if (recv_hold > 0) begin
      recv_hold--;
    end
    out_stall <= (recv_hold != 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Surface voxel from a cube pattern: set bit -> corner below iso
  function automatic voxel_t shaped(int cube, bit extreme);
    voxel_t v;
    longint d;
    v.vx = 8'($urandom_range(0, 254));
    v.vy = 8'($urandom_range(0, 254));
    v.vz = 8'($urandom_range(0, 254));
    v.mask = 8'hFF;
    v.drain = 0;
    for (int i = 0; i < 8; i++) begin
      if (cube[i]) d = extreme ? -131072 : longint'(iso) - $urandom_range(1, 40000);
      else         d = extreme ? 131071 : longint'(iso) + $urandom_range(0, 40000);
      v.c[i] = 18'(d);
    end
    return v;
  endfunction

  function automatic voxel_t any_voxel();
    voxel_t v;
    int     r;
    v = shaped($urandom_range(0, 255), $urandom_range(0, 15) == 0);
    r = $urandom_range(0, 9);
    if (r == 0) v.mask = 8'($urandom) & ~(8'h1 << $urandom_range(0, 7));
    if (r == 1) begin
      case ($urandom_range(0, 2))
        0: v.vx = 8'd255;
        1: v.vy = 8'd255;
        default: v.vz = 8'd255;
      endcase
    end
    if (r == 2) foreach (v.c[i]) v.c[i] = 18'($urandom);
    return v;
  endfunction

  task automatic settle();
    while (pending.size() > 0 || in_valid || vertices_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= val;
    case (r)
      REG_ISO: iso    = val[15:0];
      REG_CSX: cell_x = val;
      REG_CSY: cell_y = val;
      default: cell_z = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    voxel_t v;
    int     limit;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cubes, missing weight, grid edge, extremes, full tables
    pending = {pending, shaped(8'h00, 1)};
    pending = {pending, shaped(8'hFF, 1)};
    v = shaped(8'h01, 0); v.mask = 8'h7F; pending = {pending, v};
    v = shaped(8'h01, 0); v.mask = 8'h00; pending = {pending, v};
    v = shaped(8'h01, 0); v.vx = 8'd255; pending = {pending, v};
    v = shaped(8'h01, 0); v.vy = 8'd255; pending = {pending, v};
    v = shaped(8'h01, 0); v.vz = 8'd255; pending = {pending, v};
    v = shaped(8'h81, 0); v.vx = 8'd254; v.vy = 8'd254; v.vz = 8'd254; pending = {pending, v};
    v = shaped(8'h01, 0); v.vx = 8'd0; v.vy = 8'd0; v.vz = 8'd0; pending = {pending, v};
    pending = {pending, shaped(8'h01, 1)};
    pending = {pending, shaped(8'hFE, 1)};
    for (int i = 0; i < 8; i++) pending = {pending, shaped(1 << i, 0)};
    pending = {pending, shaped(8'h5A, 0)};    // four triangles
    pending = {pending, shaped(8'h3D, 0)};    // five triangles, fifteen vertices
    pending = {pending, shaped(8'h69, 0)};
    // corner exactly on iso: equal values along uncrossed edges
    v = shaped(8'h0F, 0); foreach (v.c[i]) if (i >= 4) v.c[i] = 18'(iso); pending = {pending, v};

    // register settings per phase, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin
            write_reg(REG_ISO, 24'hFFFF);
            write_reg(REG_CSX, 24'hFFFFFF);
            write_reg(REG_CSY, 24'hFFFFFF);
            write_reg(REG_CSZ, 24'hFFFFFF);
          end
          2: begin
            write_reg(REG_ISO, 24'h8000);
            write_reg(REG_CSX, 24'd1);
            write_reg(REG_CSY, 24'd3);
            write_reg(REG_CSZ, 24'h010000);
          end
          3: begin
            // zero cell size collapses every vertex to the origin
            write_reg(REG_ISO, 24'h0001);
            write_reg(REG_CSX, 24'd0);
            write_reg(REG_CSY, 24'd0);
            write_reg(REG_CSZ, 24'd0);
          end
          default: begin
            write_reg(REG_ISO, 24'($urandom_range(0, 65535)));
            write_reg(REG_CSX, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(REG_CSY, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(REG_CSZ, 24'($urandom_range(1, 24'hFFFFFF)));
          end
        endcase
      end
      no_idle = (ph == 2);
      limit = (ph == 3) ? 30 : 45;
      for (int n = 0; n < limit; n++) begin
        v = any_voxel();
        v.drain = (ph == 1 && n == 25);
        pending = {pending, v};
      end
    end

    settle();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
